// ----- rtl/core/pmq_pkg.sv -----
package pmq_pkg;

    // Fixed-point formats of the rotation entries and the quaternion.
    localparam int ROT_W         = 16;
    localparam int ROT_FRAC_BITS = 14;
    localparam int POS_W         = 32;
    localparam int QW_W          = ROT_FRAC_BITS + 1;
    localparam int QC_W          = ROT_FRAC_BITS + 2;

    // Diagonal sums need three bits of headroom over the larger of an entry and one.
    localparam int SUM_BASE_W = (ROT_W > ROT_FRAC_BITS + 1) ? ROT_W : ROT_FRAC_BITS + 1;
    localparam int SUM_W      = SUM_BASE_W + 3;
    localparam int DIFF_W     = ROT_W + 1;

    // Square root pipeline: a positive sum fits SUM_W-1 bits before the shift.
    localparam int RAD_BITS        = SUM_W - 1 + ROT_FRAC_BITS;
    localparam int STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES     = ((RAD_BITS + 1) / 2 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int ROOT_W          = SQRT_STAGES * STEPS_PER_STAGE;
    localparam int RAD_W           = 2 * ROOT_W;
    localparam int REM_W           = ROOT_W + 3;

    localparam int LANES  = 4;
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    localparam int IN_FIELDS_W = 9 * ROT_W + 3 * POS_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * POS_W + QW_W + 3 * QC_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [ROOT_W-2:0] QUAT_ONE = (ROOT_W-1)'(1) << ROT_FRAC_BITS;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic [POS_W-1:0]            pos_x;
        logic [POS_W-1:0]            pos_y;
        logic [POS_W-1:0]            pos_z;
        logic                        neg_x;
        logic                        neg_y;
        logic                        neg_z;
        sqrt_lane_t [LANES-1:0]      lane;
    } pipe_t;

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t cur);
        sqrt_lane_t       nxt;
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        r = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
        t = REM_W'({cur.root, 2'b01});
        nxt.rad = cur.rad << 2;
        if (r >= t) begin
            nxt.rem  = r - t;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = r;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ----- rtl/core/pmq_front.sv -----
module pmq_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pmq_pkg::IN_DATA_W-1:0]  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pmq_pkg::pipe_t                 out_data
);

    localparam int RW = pmq_pkg::ROT_W;
    localparam int PW = pmq_pkg::POS_W;
    localparam int SW = pmq_pkg::SUM_W;
    localparam int DW = pmq_pkg::DIFF_W;
    localparam int TB = 9 * RW;
    localparam logic signed [SW-1:0] ONE_SUM = SW'(1) << pmq_pkg::ROT_FRAC_BITS;

    logic signed [RW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic [PW-1:0]        tx, ty, tz;
    logic signed [SW-1:0] e00, e11, e22;
    logic signed [SW-1:0] sum [pmq_pkg::LANES];
    logic signed [DW-1:0] dx, dy, dz;

    logic           valid_reg;
    pmq_pkg::pipe_t data_reg, data_next;

    always_comb begin
        r00 = in_data[0*RW +: RW];
        r01 = in_data[1*RW +: RW];
        r02 = in_data[2*RW +: RW];
        r10 = in_data[3*RW +: RW];
        r11 = in_data[4*RW +: RW];
        r12 = in_data[5*RW +: RW];
        r20 = in_data[6*RW +: RW];
        r21 = in_data[7*RW +: RW];
        r22 = in_data[8*RW +: RW];
        tx  = in_data[TB +: PW];
        ty  = in_data[TB + PW +: PW];
        tz  = in_data[TB + 2*PW +: PW];

        e00 = SW'(r00);
        e11 = SW'(r11);
        e22 = SW'(r22);
        sum[pmq_pkg::LANE_W] = ONE_SUM + e00 + e11 + e22;
        sum[pmq_pkg::LANE_X] = ONE_SUM + e00 - e11 - e22;
        sum[pmq_pkg::LANE_Y] = ONE_SUM - e00 + e11 - e22;
        sum[pmq_pkg::LANE_Z] = ONE_SUM - e00 - e11 + e22;

        dx = DW'(r21) - DW'(r12);
        dy = DW'(r02) - DW'(r20);
        dz = DW'(r10) - DW'(r01);

        data_next.pos_x = (tz == pmq_pkg::POS_MIN) ? pmq_pkg::POS_MAX : -tz;
        data_next.pos_y = (tx == pmq_pkg::POS_MIN) ? pmq_pkg::POS_MAX : -tx;
        data_next.pos_z = ty;
        data_next.neg_x = dx[DW-1];
        data_next.neg_y = dy[DW-1];
        data_next.neg_z = dz[DW-1];

        for (int i = 0; i < pmq_pkg::LANES; i++) begin
            // A sum of zero or below gives a zero magnitude: feed a zero radicand.
            if (sum[i] > 0) begin
                data_next.lane[i].rad = pmq_pkg::RAD_W'($unsigned(sum[i]))
                                        << pmq_pkg::ROT_FRAC_BITS;
            end else begin
                data_next.lane[i].rad = '0;
            end
            data_next.lane[i].rem  = '0;
            data_next.lane[i].root = '0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/pmq_sqrt_stage.sv -----
module pmq_sqrt_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pmq_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pmq_pkg::pipe_t out_data
);

    logic           valid_reg;
    pmq_pkg::pipe_t data_reg, data_next;

    // Four root digits per stage on every lane; the position fields ride along.
    always_comb begin
        data_next = in_data;
        for (int i = 0; i < pmq_pkg::LANES; i++) begin
            for (int k = 0; k < pmq_pkg::STEPS_PER_STAGE; k++) begin
                data_next.lane[i] = pmq_pkg::sqrt_step(data_next.lane[i]);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/pmq_back.sv -----
module pmq_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pmq_pkg::pipe_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pmq_pkg::OUT_DATA_W-1:0]  out_data
);

    localparam int RTW = pmq_pkg::ROOT_W;
    localparam int QC  = pmq_pkg::QC_W;
    localparam int PAD = pmq_pkg::OUT_DATA_W - pmq_pkg::OUT_FIELDS_W;

    logic [RTW-2:0]  half [pmq_pkg::LANES];
    logic [QC-1:0]   mag  [pmq_pkg::LANES];
    logic [QC-1:0]   qx_out, qy_out, qz_out;

    logic                           valid_reg;
    logic [pmq_pkg::OUT_DATA_W-1:0] data_reg, data_next;

    always_comb begin
        for (int i = 0; i < pmq_pkg::LANES; i++) begin
            half[i] = in_data.lane[i].root[RTW-1:1];
            // A matrix that is not a rotation can push a magnitude past one.
            if (half[i] > pmq_pkg::QUAT_ONE) begin
                mag[i] = QC'(pmq_pkg::QUAT_ONE);
            end else begin
                mag[i] = QC'(half[i]);
            end
        end

        // Output x is -qz, y is -qx, z is qy.
        qx_out = in_data.neg_z ? mag[pmq_pkg::LANE_Z] : -mag[pmq_pkg::LANE_Z];
        qy_out = in_data.neg_x ? mag[pmq_pkg::LANE_X] : -mag[pmq_pkg::LANE_X];
        qz_out = in_data.neg_y ? -mag[pmq_pkg::LANE_Y] : mag[pmq_pkg::LANE_Y];

        data_next = {{PAD{1'b0}}, qz_out, qy_out, qx_out,
                     mag[pmq_pkg::LANE_W][pmq_pkg::QW_W-1:0],
                     in_data.pos_z, in_data.pos_y, in_data.pos_x};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/pose_matrix_to_quaternion_unit.sv -----
// Pose matrix to remapped position and quaternion. Each input item is one 3x4
// pose: nine signed Q1.14 rotation entries and three signed Q15.16 translation
// entries. Each result item carries the position (-tz, -tx, ty), with negation
// of the most negative value saturating to the most positive, and the
// quaternion (w, -qz, -qx, qy). Every quaternion magnitude is
// sqrt(1 +/- diagonal terms) / 2 truncated to Q1.14, zero where the radicand
// is not positive and clamped to 1.0 for a matrix that is not a rotation; the
// signs of x, y and z follow the off-diagonal differences, with zero taken as
// positive. The block is a six-stage pipeline with no state between items: it
// accepts one item per clock while the output is not stalled, and each result
// is registered in the output stage. Four of the stages are the square root,
// which produces four root digits per stage on four lanes at once, framed by
// an input stage that forms the diagonal sums and an output stage that halves,
// clamps, applies signs and remaps. Each stage holds its item while its
// successor is not ready, so a stall on the result side backs up into the
// pipeline without losing or repeating an item, and empty stages keep filling
// while a finished result waits.
module pose_matrix_to_quaternion_unit (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20,
    // rot_21, rot_22 (16 bits each), trans_x, trans_y, trans_z (32 bits each).
    input  logic [pmq_pkg::IN_DATA_W-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: out_pos_x, out_pos_y, out_pos_z (32 bits each), out_quat_w
    // (15 bits), out_quat_x, out_quat_y, out_quat_z (16 bits each), one zero bit.
    output logic [pmq_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int NS = pmq_pkg::SQRT_STAGES;

    // Handshake and payload between stages: index 0 is the front stage output,
    // index k is the output of square root stage k.
    logic           valid [NS+1];
    logic           ready [NS+1];
    pmq_pkg::pipe_t data  [NS+1];

    pmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_data  (data[0])
    );

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        pmq_sqrt_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_data   (data[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_data  (data[k+1])
        );
    end

    pmq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid[NS]),
        .in_ready  (ready[NS]),
        .in_data   (data[NS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
